// File: sv/ipv4_flow_key_extractor_core_assert.svh
// ----------------------------------------------------------------------------
// Flow key extractor assertion macros
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef IPV4_FLOW_KEY_EXTRACTOR_CORE_ASSERT_SVH
`define IPV4_FLOW_KEY_EXTRACTOR_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define FKX_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flow key extractor: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define FKX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flow key extractor: next-cycle check failed");

// The condition holds at every clock edge outside reset.
`define FKX_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("flow key extractor: invariant failed");

`endif

// File: sv/fkx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow key extractor package
// Protocol numbers, header positions, status codes and the transaction types
// shared by the parser, the result queue and the top level.
// ----------------------------------------------------------------------------
package fkx_pkg;

   // IP protocol numbers that carry a port pair or SPI, plus protocol zero.
   localparam logic [7:0] PROTO_TCP     = 8'd6;
   localparam logic [7:0] PROTO_UDP     = 8'd17;
   localparam logic [7:0] PROTO_DCCP    = 8'd33;
   localparam logic [7:0] PROTO_ESP     = 8'd50;
   localparam logic [7:0] PROTO_AH      = 8'd51;
   localparam logic [7:0] PROTO_SCTP    = 8'd132;
   localparam logic [7:0] PROTO_UDPLITE = 8'd136;
   localparam logic [7:0] PROTO_NONE    = 8'd0;

   // Link type and fragment field masks.
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] IP_MF          = 16'h2000;
   localparam logic [15:0] IP_FRAG_OFFSET = 16'h1FFF;
   localparam logic [15:0] FRAG_MASK      = IP_MF | IP_FRAG_OFFSET;
   localparam logic [7:0]  FRAG_HI_MASK   = FRAG_MASK[15:8];
   localparam logic [7:0]  FRAG_LO_MASK   = FRAG_MASK[7:0];

   // Byte positions within the IPv4 header.
   localparam int          POS_W        = 7;
   localparam logic [6:0]  POS_MAX      = 7'd127;
   localparam logic [6:0]  POS_VER_IHL  = 7'd0;
   localparam logic [6:0]  POS_FRAG_HI  = 7'd6;
   localparam logic [6:0]  POS_FRAG_LO  = 7'd7;
   localparam logic [6:0]  POS_PROTO    = 7'd9;
   localparam logic [6:0]  POS_SRC_0    = 7'd12;
   localparam logic [6:0]  POS_SRC_3    = 7'd15;
   localparam logic [6:0]  POS_DST_0    = 7'd16;
   localparam logic [6:0]  POS_HDR_LAST = 7'd19;
   localparam logic [6:0]  AH_SKIP      = 7'd4;
   localparam logic [6:0]  PORT_BYTES   = 7'd4;
   localparam logic [6:0]  PORT_LAST    = PORT_BYTES - 7'd1;
   localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;

   // Result status codes.
   localparam logic [1:0] ST_NORMAL = 2'd0;
   localparam logic [1:0] ST_FRAG   = 2'd1;
   localparam logic [1:0] ST_ERROR  = 2'd2;

   // One input transaction.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [15:0] ether_type;
      logic        frag_report;
   } fkx_req_type;

   // One result transaction.
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [31:0] port_pair;
      logic [7:0]  l4_proto;
      logic [6:0]  transport_offset;
   } fkx_result_type;

   // How a protocol locates its port bytes.
   typedef struct packed {
      logic has_ports;
      logic ah_skip;
   } fkx_port_class_type;

   function automatic fkx_port_class_type port_class(input logic [7:0] proto);
      fkx_port_class_type cls;
      cls = '0;
      case (proto) inside
         PROTO_TCP, PROTO_UDP, PROTO_DCCP,
         PROTO_ESP, PROTO_SCTP, PROTO_UDPLITE: begin
            cls.has_ports = 1'b1;
         end
         PROTO_AH: begin
            cls.has_ports = 1'b1;
            cls.ah_skip   = 1'b1;
         end
         default: begin
            cls = '0;
         end
      endcase
      return cls;
   endfunction

endpackage

// File: sv/fkx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow key extractor channels
// Valid/ready channels for packet bytes in and flow keys out.
// ----------------------------------------------------------------------------
interface fkx_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        first_byte;
   logic        last_byte;
   logic [15:0] ether_type;
   logic        frag_report;

   modport source (output valid, data_byte, first_byte, last_byte, ether_type,
                   frag_report, input ready);
   modport sink   (input valid, data_byte, first_byte, last_byte, ether_type,
                   frag_report, output ready);
endinterface

interface fkx_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [31:0] port_pair;
   logic [7:0]  l4_proto;
   logic [6:0]  transport_offset;

   modport source (output valid, status, src_addr, dst_addr, port_pair, l4_proto,
                   transport_offset, input ready);
   modport sink   (input valid, status, src_addr, dst_addr, port_pair, l4_proto,
                   transport_offset, output ready);
endinterface

// File: sv/ipv4_flow_key_extractor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 flow key extractor
// Takes packets one byte per transaction on req_bus, starting at the network
// header, and returns one flow key transaction per packet on rsp_bus: status,
// source and destination address, port pair, protocol and transport offset.
// The ether type and fragment-report flag are sampled with the first byte.
// Non-IPv4 packets give a normal result with a zero key on their first byte;
// IPv4 packets give their result on header byte 19 or on the last port byte,
// and a packet that ends first gives an error on its last byte.
// The deciding byte's result is written into the result queue and offered on rsp_bus from there.
// Throughput: one byte per cycle while the result queue has room; the parser is
// a single pass of logic between the byte handshake and a two-entry result queue.
// req_bus.ready drops only while both queue entries hold results the receiver
// has not taken, so a stalled receiver stalls input after two pending keys.
// Reset (synchronous, active high) closes any open packet and empties the
// queue; bytes before the next first byte are ignored.
// ----------------------------------------------------------------------------
module ipv4_flow_key_extractor_core (
   input  logic      clock,
   input  logic      reset,
   fkx_req_if.sink   req_bus,
   fkx_rsp_if.source rsp_bus
);

   fkx_pkg::fkx_req_type    item;
   fkx_pkg::fkx_result_type res;
   logic                    res_valid;
   logic                    accept;
   logic                    full;

   // Accept a byte whenever the result queue has room.
   assign req_bus.ready = !full;
   assign accept        = req_bus.valid && req_bus.ready;

   // Gather the input transaction fields.
   assign item.data_byte   = req_bus.data_byte;
   assign item.first_byte  = req_bus.first_byte;
   assign item.last_byte   = req_bus.last_byte;
   assign item.ether_type  = req_bus.ether_type;
   assign item.frag_report = req_bus.frag_report;

   fkx_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   fkx_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (full),
      .rsp_bus   (rsp_bus)
   );

endmodule

// File: sv/fkx_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow key extractor header parser
// Tracks the byte position in the packet, captures header fields and the
// port bytes, and decides the single result of each packet.
// ----------------------------------------------------------------------------
`include "ipv4_flow_key_extractor_core_assert.svh"

module fkx_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  fkx_pkg::fkx_req_type   item,
   output logic                   res_valid,
   output fkx_pkg::fkx_result_type res
);

   // Control state.
   logic                     open_ff, open_in;
   logic                     done_ff, done_in;
   logic [fkx_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                     chk_ff, chk_in;

   // Captured header fields.
   logic [3:0]  hw_ff, hw_in;
   logic        frag_ff, frag_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [23:0] ports_ff, ports_in;

   // Values seen by the current byte, with a first byte restarting the packet.
   logic                      eff_open;
   logic                      eff_done;
   logic [fkx_pkg::POS_W-1:0] eff_pos;
   logic                      eff_chk;
   logic                      non_ip;

   // Port window.
   fkx_pkg::fkx_port_class_type cls;
   logic [6:0] port_start;
   logic [6:0] port_diff;
   logic       in_window;

   assign eff_open = item.first_byte | open_ff;
   assign eff_done = ~item.first_byte & done_ff;
   assign eff_pos  = item.first_byte ? '0 : pos_ff;
   assign eff_chk  = item.first_byte ? item.frag_report : chk_ff;
   assign non_ip   = item.first_byte && (item.ether_type != fkx_pkg::ETHERTYPE_IPV4);

   assign cls        = fkx_pkg::port_class(proto_ff);
   assign port_start = {1'b0, hw_ff, 2'b00} + (cls.ah_skip ? fkx_pkg::AH_SKIP : 7'd0);
   assign port_diff  = eff_pos - port_start;
   assign in_window  = (eff_pos >= port_start) && (port_diff < fkx_pkg::PORT_BYTES);

   // Next state and result for one accepted transaction.
   always_comb begin
      open_in   = open_ff;
      done_in   = done_ff;
      pos_in    = pos_ff;
      chk_in    = chk_ff;
      hw_in     = hw_ff;
      frag_in   = frag_ff;
      proto_in  = proto_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      ports_in  = ports_ff;
      res_valid = 1'b0;
      res       = '0;

      if (accept) begin
         chk_in  = eff_chk;
         pos_in  = eff_pos;
         done_in = eff_done;
         open_in = eff_open && !item.last_byte;

         if (non_ip) begin
            // Not IPv4: a normal result with an all-zero key right away.
            res_valid  = 1'b1;
            res.status = fkx_pkg::ST_NORMAL;
            done_in    = 1'b1;
         end else if (eff_open && !eff_done) begin
            // Capture header fields at their fixed positions.
            case (eff_pos) inside
               fkx_pkg::POS_VER_IHL: begin
                  hw_in = item.data_byte[3:0];
               end
               fkx_pkg::POS_FRAG_HI: begin
                  frag_in = |(item.data_byte & fkx_pkg::FRAG_HI_MASK);
               end
               fkx_pkg::POS_FRAG_LO: begin
                  frag_in = frag_ff | (|(item.data_byte & fkx_pkg::FRAG_LO_MASK));
               end
               fkx_pkg::POS_PROTO: begin
                  proto_in = item.data_byte;
               end
               [fkx_pkg::POS_SRC_0:fkx_pkg::POS_SRC_3]: begin
                  src_in = {src_ff[23:0], item.data_byte};
               end
               [fkx_pkg::POS_DST_0:fkx_pkg::POS_HDR_LAST]: begin
                  dst_in = {dst_ff[23:0], item.data_byte};
               end
               default: begin
                  hw_in = hw_ff;
               end
            endcase

            if (eff_pos == fkx_pkg::POS_HDR_LAST) begin
               // Header decision on the last fixed header byte.
               if (hw_ff < fkx_pkg::MIN_HDR_WORDS) begin
                  res_valid  = 1'b1;
                  res.status = fkx_pkg::ST_ERROR;
               end else if (eff_chk && frag_ff) begin
                  res_valid  = 1'b1;
                  res.status = fkx_pkg::ST_FRAG;
               end else if (proto_ff == fkx_pkg::PROTO_NONE) begin
                  res_valid  = 1'b1;
                  res.status = fkx_pkg::ST_ERROR;
               end else if (!cls.has_ports) begin
                  res_valid            = 1'b1;
                  res.status           = fkx_pkg::ST_NORMAL;
                  res.src_addr         = src_ff;
                  res.dst_addr         = {dst_ff[23:0], item.data_byte};
                  res.l4_proto         = proto_ff;
                  res.transport_offset = {1'b0, hw_ff, 2'b00};
               end
            end else if ((eff_pos > fkx_pkg::POS_HDR_LAST) && cls.has_ports && in_window) begin
               // Collect the four port bytes; the last one completes the key.
               ports_in = {ports_ff[15:0], item.data_byte};
               if (port_diff == fkx_pkg::PORT_LAST) begin
                  res_valid            = 1'b1;
                  res.status           = fkx_pkg::ST_NORMAL;
                  res.src_addr         = src_ff;
                  res.dst_addr         = dst_ff;
                  res.port_pair        = {ports_ff, item.data_byte};
                  res.l4_proto         = proto_ff;
                  res.transport_offset = port_start;
               end
            end

            // A packet that ends before its result is truncated.
            if (!res_valid && item.last_byte) begin
               res_valid  = 1'b1;
               res        = '0;
               res.status = fkx_pkg::ST_ERROR;
            end

            done_in = res_valid;
            pos_in  = (eff_pos == fkx_pkg::POS_MAX) ? eff_pos : eff_pos + 7'd1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         done_ff <= 1'b0;
         pos_ff  <= '0;
         chk_ff  <= 1'b0;
      end else begin
         open_ff <= open_in;
         done_ff <= done_in;
         pos_ff  <= pos_in;
         chk_ff  <= chk_in;
      end
   end

   // Captured field registers.
   always_ff @(posedge clock) begin
      hw_ff    <= hw_in;
      frag_ff  <= frag_in;
      proto_ff <= proto_in;
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      ports_ff <= ports_in;
   end

   // A result only comes from an accepted transaction.
   `FKX_ASSERT_SAME(a_res_needs_accept, clock, reset, res_valid, accept)
   // After a result the packet is marked done.
   `FKX_ASSERT_NEXT(a_done_after_res, clock, reset, accept && res_valid, done_ff)
   // A done packet gives nothing more until a new first byte.
   `FKX_ASSERT_SAME(a_no_second_res, clock, reset,
      accept && done_ff && !item.first_byte, !res_valid)
   // Fragment and error results carry an all-zero key.
   `FKX_ASSERT_SAME(a_zero_key_on_fail, clock, reset,
      res_valid && (res.status != fkx_pkg::ST_NORMAL),
      (res.src_addr == '0) && (res.port_pair == '0) && (res.transport_offset == '0))

endmodule

// File: sv/fkx_rsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow key extractor result queue
// Two-entry output register that decouples the parser from the result
// receiver, so bytes keep flowing while one finished key waits.
// ----------------------------------------------------------------------------
`include "ipv4_flow_key_extractor_core_assert.svh"

module fkx_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  fkx_pkg::fkx_result_type push_data,
   output logic                    full,
   fkx_rsp_if.source               rsp_bus
);

   fkx_pkg::fkx_result_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   fkx_pkg::fkx_result_type head;

   assign full = (count_ff == 2'd2);
   assign pop  = rsp_bus.valid && rsp_bus.ready;
   assign head = slot_ff[rd_ptr_ff];

   // Drive the result channel from the oldest entry.
   assign rsp_bus.valid            = (count_ff != 2'd0);
   assign rsp_bus.status           = head.status;
   assign rsp_bus.src_addr         = head.src_addr;
   assign rsp_bus.dst_addr         = head.dst_addr;
   assign rsp_bus.port_pair        = head.port_pair;
   assign rsp_bus.l4_proto         = head.l4_proto;
   assign rsp_bus.transport_offset = head.transport_offset;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Never write into a full queue.
   `FKX_ASSERT_SAME(a_no_push_full, clock, reset, push, !full)
   // Occupancy stays within the two entries.
   `FKX_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff != 2'd3)
   // A lone push grows the queue by one.
   `FKX_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop,
      count_ff == $past(count_ff) + 2'd1)

endmodule
